>>> design/rsa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// RSA modular exponentiation package
// Shared constants and types.
// ----------------------------------------------------------------------------
package rsa_pkg;
  localparam int unsigned VALUE_W = 16;
  localparam int unsigned CODE_W  = 17;
  localparam logic [VALUE_W-1:0] CODE_OFFSET = 16'd96;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_MODULUS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PUB_EXP  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PRIV_EXP = 2'd2;

  localparam logic CMD_ENCRYPT = 1'b0;
  localparam logic CMD_DECRYPT = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_SQUARE,
    ST_MULT,
    ST_DONE
  } state_t;
endpackage
`default_nettype wire

>>> design/rsa_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// RSA stream interface
// Valid/ready channel with a generic payload.
// ----------------------------------------------------------------------------
interface rsa_if #(parameter int unsigned W = 17);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> design/rsa_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// RSA modular multiplier cell
// One step of MSB-first interleaved modular multiplication: acc = 2*acc + bit*a
// mod m. Each cell takes the partial result from its left neighbor.
// ----------------------------------------------------------------------------
module rsa_cell #(
  parameter int unsigned W = 16
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         vld_i,
  input  wire logic [W-1:0] acc_i,
  input  wire logic [W-1:0] a_i,
  input  wire logic [W-1:0] b_i,
  input  wire logic [W-1:0] m_i,
  input  wire logic         bit_i,
  output logic              vld_o,
  output logic [W-1:0]      acc_o,
  output logic [W-1:0]      a_o,
  output logic [W-1:0]      b_o,
  output logic [W-1:0]      m_o
);
  logic [W+1:0] dbl, d1, s, s1;
  logic [W-1:0] acc_nxt;

  always_comb begin
    dbl = {1'b0, acc_i, 1'b0};
    d1  = (dbl >= {2'b00, m_i}) ? dbl - {2'b00, m_i} : dbl;
    s   = d1 + (bit_i ? {2'b00, a_i} : '0);
    s1  = (s >= {2'b00, m_i}) ? s - {2'b00, m_i} : s;
    acc_nxt = s1[W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_o <= 1'b0;
    end else begin
      vld_o <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    acc_o <= acc_nxt;
    a_o   <= a_i;
    b_o   <= b_i;
    m_o   <= m_i;
  end
endmodule
`default_nettype wire

>>> design/rsa_mulmod.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// RSA modular multiplier chain
// A row of W cells, one multiplier bit each, MSB first; each cell registers its result.
// ----------------------------------------------------------------------------
module rsa_mulmod #(
  parameter int unsigned W = 16
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         start,
  input  wire logic [W-1:0] a,
  input  wire logic [W-1:0] b,
  input  wire logic [W-1:0] m,
  output logic              done,
  output logic [W-1:0]      p
);
  logic [W:0]   vld;
  logic [W-1:0] acc [W+1];
  logic [W-1:0] av  [W+1];
  logic [W-1:0] bv  [W+1];
  logic [W-1:0] mv  [W+1];

  assign vld[0] = start;
  assign acc[0] = '0;
  assign av[0]  = a;
  assign bv[0]  = b;
  assign mv[0]  = m;

  for (genvar i = 0; i < W; i++) begin : g_cell
    rsa_cell #(.W(W)) u_cell (
      .clk(clk), .rst_n(rst_n), .vld_i(vld[i]), .acc_i(acc[i]), .a_i(av[i]),
      .b_i(bv[i]), .m_i(mv[i]), .bit_i(bv[i][W-1-i]),
      .vld_o(vld[i+1]), .acc_o(acc[i+1]), .a_o(av[i+1]), .b_o(bv[i+1]),
      .m_o(mv[i+1])
    );
  end

  assign done = vld[W];
  assign p    = acc[W];
endmodule
`default_nettype wire

>>> design/rsa_modular_exponentiation_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// RSA modular exponentiation top
// Square-and-multiply with a systolic modular multiplier chain.
// ----------------------------------------------------------------------------
// One item at a time. Every modular multiplication runs through a chain of
// BW = max(MOD_WIDTH, 16) cells, and an item takes one reduction of the base
// first, then a square per exponent bit and a multiply per set bit. Encrypt
// values below 96 and a modulus below 2 skip the multiplications and go
// straight to the done state. A new item is taken from the cycle after the
// result is loaded. The result waits in an output register; the next result
// is held back only while that register is full.
module rsa_modular_exponentiation_top
  import rsa_pkg::*;
#(
  parameter int unsigned MOD_WIDTH = 16,
  parameter int unsigned EXP_WIDTH = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [((MOD_WIDTH > EXP_WIDTH) ? MOD_WIDTH : EXP_WIDTH)-1:0] cfg_data,
  rsa_if.sink                       in_ch,
  rsa_if.source                     out_ch
);
  localparam int unsigned EXP_CW = $clog2(EXP_WIDTH + 1);
  localparam int unsigned BW = (MOD_WIDTH > VALUE_W) ? MOD_WIDTH : VALUE_W;

  logic [MOD_WIDTH-1:0] modulus_r;
  logic [EXP_WIDTH-1:0] pub_exp_r, priv_exp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      modulus_r  <= MOD_WIDTH'(35821);
      pub_exp_r  <= EXP_WIDTH'(3);
      priv_exp_r <= EXP_WIDTH'(23595);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MODULUS:  modulus_r  <= cfg_data[MOD_WIDTH-1:0];
        REG_PUB_EXP:  pub_exp_r  <= cfg_data[EXP_WIDTH-1:0];
        REG_PRIV_EXP: priv_exp_r <= cfg_data[EXP_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  logic                 in_cmd;
  logic [VALUE_W-1:0]   in_value;
  assign in_cmd   = in_ch.data[VALUE_W];
  assign in_value = in_ch.data[VALUE_W-1:0];

  state_t state_r, state_nxt;
  logic [EXP_WIDTH-1:0] exp_r;
  logic [EXP_CW-1:0]    cnt_r;
  logic [MOD_WIDTH-1:0] acc_r, base_r;
  logic [BW-1:0]        raw_r;       // base before reduction
  logic                 busy_r;      // multiplication in flight
  logic                 out_vld_r;
  logic [VALUE_W-1:0]   res_r;
  logic                 err_r;
  logic                 out_err_r;

  logic                 mm_start, mm_done;
  logic [BW-1:0]        mm_a, mm_b, mm_p;
  logic                 small_mod;
  logic                 in_fire, bad_enc;
  logic                 done_go;

  assign small_mod = modulus_r < MOD_WIDTH'(2);
  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_fire = in_ch.valid && in_ch.ready;
  assign bad_enc = (in_cmd == CMD_ENCRYPT) && (in_value < CODE_OFFSET);
  // result moves to the output register once it is free or being emptied
  assign done_go = (state_r == ST_DONE) && (!out_vld_r || out_ch.ready);

  // Base reduction runs as 1 * raw through the chain, which leaves raw mod m.
  always_comb begin
    mm_a = BW'(acc_r);
    mm_b = BW'(acc_r);
    unique case (state_r)
      ST_REDUCE: begin
        mm_a = BW'(1);
        mm_b = raw_r;
      end
      ST_MULT: mm_b = BW'(base_r);
      default: ;
    endcase
  end
  assign mm_start = !busy_r &&
                    (state_r == ST_REDUCE || state_r == ST_SQUARE || state_r == ST_MULT);

  rsa_mulmod #(.W(BW)) u_mul (
    .clk(clk), .rst_n(rst_n), .start(mm_start), .a(mm_a), .b(mm_b), .m(BW'(modulus_r)),
    .done(mm_done), .p(mm_p)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (in_fire) state_nxt = (bad_enc || small_mod) ? ST_DONE : ST_REDUCE;
      ST_REDUCE: if (mm_done) state_nxt = ST_SQUARE;
      ST_SQUARE: if (mm_done) state_nxt = exp_r[EXP_WIDTH-1] ? ST_MULT :
                                (cnt_r == EXP_CW'(1)) ? ST_DONE : ST_SQUARE;
      ST_MULT:   if (mm_done) state_nxt = (cnt_r == EXP_CW'(1)) ? ST_DONE : ST_SQUARE;
      ST_DONE:   if (done_go) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      busy_r    <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (mm_start) busy_r <= 1'b1;
      else if (mm_done) busy_r <= 1'b0;
      if (done_go) out_vld_r <= 1'b1;
      else if (out_ch.valid && out_ch.ready) out_vld_r <= 1'b0;
    end
  end

  logic adv;
  assign adv = mm_done && ((state_r == ST_SQUARE && !exp_r[EXP_WIDTH-1]) ||
                           state_r == ST_MULT);

  always_ff @(posedge clk) begin
    if (in_fire) begin
      raw_r <= BW'((in_cmd == CMD_DECRYPT) ? in_value : in_value - CODE_OFFSET);
      exp_r <= (in_cmd == CMD_DECRYPT) ? priv_exp_r : pub_exp_r;
      cnt_r <= EXP_CW'(EXP_WIDTH);
      acc_r <= (modulus_r == MOD_WIDTH'(1)) ? '0 : MOD_WIDTH'(1);
      err_r <= bad_enc;
    end
    if (state_r == ST_REDUCE && mm_done) base_r <= mm_p[MOD_WIDTH-1:0];
    if (state_r == ST_SQUARE && mm_done) acc_r <= mm_p[MOD_WIDTH-1:0];
    if (state_r == ST_MULT && mm_done) acc_r <= mm_p[MOD_WIDTH-1:0];
    if (adv) begin
      exp_r <= {exp_r[EXP_WIDTH-2:0], 1'b0};
      cnt_r <= cnt_r - EXP_CW'(1);
    end
    if (done_go) begin
      res_r     <= (err_r || small_mod) ? '0 : VALUE_W'(acc_r);
      out_err_r <= err_r;
    end
  end

  logic [CODE_W-1:0] shifted;
  assign shifted = out_err_r ? '0 : CODE_W'(res_r) + CODE_W'(CODE_OFFSET);
  assign out_ch.valid = out_vld_r;
  assign out_ch.data  = {out_err_r, shifted, res_r};
endmodule
`default_nettype wire
